[sv/escaped_packet_deframer_xor_defines.svh]
// ============================================================================
// Assertion macros for the escaped packet deframer
// Shared property templates clocked on aclk and disabled during reset.
// ============================================================================
`ifndef ESCAPED_PACKET_DEFRAMER_XOR_DEFINES_SVH
`define ESCAPED_PACKET_DEFRAMER_XOR_DEFINES_SVH

// Same-cycle implication.
`define EPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define EPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/epd_pkg.sv]
// ============================================================================
// Escaped packet deframer package
// Byte codes, frame position codes, register indexes and the result type.
// ============================================================================
package epd_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 6;
    localparam int MASK_W  = 5;
    localparam int CFG_INDEX_W = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    localparam logic [BYTE_W-1:0] START_BYTE     = 8'hFC;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE    = 8'hFB;
    localparam logic [BYTE_W-1:0] ESCAPE_ADD     = 8'h10;
    localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hFF;
    localparam logic [BYTE_W-1:0] CHECKSUM_SEED  = 8'h2A;

    localparam logic [MASK_W-1:0] LENGTH_RESET   = 5'd31;
    localparam logic [BYTE_W-1:0] OWN_ADDR_RESET = 8'd1;
    localparam logic [MASK_W-1:0] MASK_RESET     = 5'd31;

    // Frame position codes; values 0 to 33 are the next buffer index.
    localparam logic [INDEX_W-1:0] PHASE_SENDER = 6'd0;
    localparam logic [INDEX_W-1:0] PHASE_LENGTH = 6'd1;
    localparam logic [INDEX_W-1:0] PHASE_LAST   = 6'd33;
    localparam logic [INDEX_W-1:0] PHASE_IDLE   = 6'd62;
    localparam logic [INDEX_W-1:0] PHASE_DEST   = 6'd63;
    localparam logic [INDEX_W-1:0] CHECKSUM_GAP = 6'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_MASK = 8'd1;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_checksum;
        logic               is_broadcast;
        logic               packet_bad;
        logic               packet_good;
        logic [BYTE_W-1:0]  stored_value;
        logic [INDEX_W-1:0] stored_index;
        logic               stored_valid;
    } epd_result_t;

endpackage

[sv/epd_core.sv]
// ============================================================================
// Escaped packet deframer core
// Frame state registers and the per-byte unescape, address and checksum step.
// ============================================================================
module epd_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  logic [epd_pkg::BYTE_W-1:0]          rx_byte,
    input  logic [epd_pkg::BYTE_W-1:0]          own_address,
    input  logic [epd_pkg::MASK_W-1:0]          length_mask,
    output epd_pkg::epd_result_t                result
);

    logic [epd_pkg::INDEX_W-1:0] phase_reg, phase_next;
    logic                        esc_reg, esc_next;
    logic                        bcast_reg, bcast_next;
    logic [epd_pkg::BYTE_W-1:0]  csum_reg, csum_next;
    logic [epd_pkg::MASK_W-1:0]  len_reg, len_next;
    logic [epd_pkg::BYTE_W-1:0]  b;
    logic [epd_pkg::INDEX_W-1:0] limit;

    assign limit = epd_pkg::INDEX_W'(len_reg & length_mask) + epd_pkg::CHECKSUM_GAP;

    always_comb begin
        b          = rx_byte;
        phase_next = phase_reg;
        esc_next   = esc_reg;
        bcast_next = bcast_reg;
        csum_next  = csum_reg;
        len_next   = len_reg;
        result     = '0;
        if (rx_byte == epd_pkg::START_BYTE) begin
            phase_next = epd_pkg::PHASE_DEST;
        end else if (rx_byte == epd_pkg::ESCAPE_BYTE) begin
            esc_next = 1'b1;
        end else begin
            if (esc_reg) begin
                b        = rx_byte + epd_pkg::ESCAPE_ADD;
                esc_next = 1'b0;
            end
            if (phase_reg == epd_pkg::PHASE_DEST) begin
                if (b == own_address || b == epd_pkg::BROADCAST_ADDR) begin
                    phase_next = epd_pkg::PHASE_SENDER;
                    csum_next  = epd_pkg::CHECKSUM_SEED ^ b;
                    bcast_next = (b == epd_pkg::BROADCAST_ADDR);
                end else begin
                    phase_next = epd_pkg::PHASE_IDLE;
                end
            end else if (phase_reg == epd_pkg::PHASE_SENDER) begin
                len_next            = epd_pkg::LENGTH_RESET;
                csum_next           = csum_reg ^ b;
                result.stored_valid = 1'b1;
                result.stored_index = epd_pkg::PHASE_SENDER;
                result.stored_value = b;
                phase_next          = epd_pkg::PHASE_LENGTH;
            end else if (phase_reg <= epd_pkg::PHASE_LAST) begin
                if (phase_reg >= limit) begin
                    result.packet_good = (csum_reg == b);
                    result.packet_bad  = (csum_reg != b);
                    phase_next         = epd_pkg::PHASE_IDLE;
                end else begin
                    if (phase_reg == epd_pkg::PHASE_LENGTH) begin
                        len_next = b[epd_pkg::MASK_W-1:0];
                    end
                    csum_next           = csum_reg ^ b;
                    result.stored_valid = 1'b1;
                    result.stored_index = phase_reg;
                    result.stored_value = b;
                    phase_next          = phase_reg + 6'd1;
                end
            end
        end
        result.is_broadcast   = bcast_next;
        result.frame_checksum = csum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= epd_pkg::PHASE_IDLE;
            esc_reg   <= 1'b0;
            bcast_reg <= 1'b0;
            csum_reg  <= '0;
            len_reg   <= epd_pkg::LENGTH_RESET;
        end else if (step) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            bcast_reg <= bcast_next;
            csum_reg  <= csum_next;
            len_reg   <= len_next;
        end
    end

endmodule

[sv/escaped_packet_deframer_xor.sv]
// ============================================================================
// Escaped packet deframer with XOR checksum
// Unstuffs a received byte stream, filters frames by address and checks them.
// ============================================================================
// Usage: one raw line byte enters per beat on the s_ channel. Every input beat
// produces exactly one result beat on the m_ channel, carrying the stored byte
// and its buffer index, the good or bad checksum flags, the broadcast flag and
// the running checksum. The own address and the length mask are written on the
// cfg_ channel, which is ready whenever reset is released; the user must make
// writes only while no beat is in flight; the block does not enforce this. An
// accepted byte is held in the input register, the frame step runs between it
// and the two-entry output buffer, and the result is offered on the m_ channel
// from that buffer. The block sustains one beat per cycle while the receiver
// keeps taking results. When the receiver stalls, the output buffer fills with
// two results and the input register holds a third; s_tready then stays low
// until the cycle after a result is taken. Synchronous reset empties both
// stages, holds s_tready and cfg_ready low, returns the frame logic to waiting
// for a start byte and restores the own address to 1 and the length mask to 31.
// ============================================================================
module escaped_packet_deframer_xor (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [epd_pkg::S_TDATA_W-1:0]        s_tdata,   // [7:0] rx_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] stored_valid, [6:1] stored_index, [14:7] stored_value, [15] packet_good,
    // [16] packet_bad, [17] is_broadcast, [25:18] frame_checksum, [31:26] zero
    output logic [epd_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [epd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [epd_pkg::BYTE_W-1:0]           cfg_data
);

    logic [epd_pkg::BYTE_W-1:0] own_addr_reg;
    logic [epd_pkg::MASK_W-1:0] mask_reg;
    logic                       in_valid_reg;
    logic [epd_pkg::BYTE_W-1:0] in_byte_reg;
    epd_pkg::epd_result_t       result;
    epd_pkg::epd_result_t       out0_reg, out1_reg;
    logic [1:0]                 count_reg;
    logic                       advance, push, pop;
    logic [1:0]                 wpos;

    assign cfg_ready = aresetn;
    assign pop       = m_tvalid && m_tready;
    assign advance   = in_valid_reg && (count_reg != 2'd2);
    assign push      = advance;
    assign s_tready  = aresetn && (!in_valid_reg || advance);
    assign wpos      = count_reg - {1'b0, pop};
    assign m_tvalid  = (count_reg != 2'd0);
    assign m_tdata   = epd_pkg::M_TDATA_W'(out0_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= epd_pkg::OWN_ADDR_RESET;
            mask_reg     <= epd_pkg::MASK_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                epd_pkg::REG_OWN_ADDRESS: own_addr_reg <= cfg_data;
                epd_pkg::REG_LENGTH_MASK: mask_reg     <= cfg_data[epd_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    epd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .own_address (own_addr_reg),
        .length_mask (mask_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && count_reg == 2'd2) begin
            out0_reg <= out1_reg;
        end
        if (push && wpos == 2'd0) begin
            out0_reg <= result;
        end
        if (push && wpos == 2'd1) begin
            out1_reg <= result;
        end
    end

endmodule

[sv/epd_checker.sv]
// ============================================================================
// Escaped packet deframer port checker
// Port-level checks on result beats, bound to the top level.
// ============================================================================
`include "escaped_packet_deframer_xor_defines.svh"

module epd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [epd_pkg::M_TDATA_W-1:0]      m_tdata
);

    `EPD_ASSERT_NOW(a_good_bad_excl, m_tvalid, !(m_tdata[15] && m_tdata[16]),
        "good and bad together")

    `EPD_ASSERT_NOW(a_store_not_verdict, m_tvalid && m_tdata[0],
        !m_tdata[15] && !m_tdata[16] && (m_tdata[6:1] <= epd_pkg::PHASE_LAST),
        "stored byte with verdict or bad index")

    `EPD_ASSERT_NOW(a_unstored_zero, m_tvalid && !m_tdata[0],
        m_tdata[6:1] == '0 && m_tdata[14:7] == '0 && m_tdata[31:26] == '0,
        "unstored beat carries data")

    `EPD_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")

endmodule

bind escaped_packet_deframer_xor epd_checker u_epd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/tb_escaped_packet_deframer_xor.sv]
// ============================================================================
// Testbench for the escaped packet deframer with XOR checksum
// Streams byte-stuffed frames, broken frames and line noise into the block
// under random source gaps and sink stalls. A scoreboard predicts every result
// beat from its own frame tracker and compares it field by field. The own
// address and the length mask are changed between phases while the block is
// idle, including once in the middle of a frame.
// ============================================================================
`timescale 1ns / 1ps

module tb_escaped_packet_deframer_xor;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int RESULT_W = $bits(epd_pkg::epd_result_t);

    class deframe_scoreboard;
        logic [epd_pkg::BYTE_W-1:0]  own_address;
        logic [epd_pkg::MASK_W-1:0]  length_mask;
        logic [epd_pkg::INDEX_W-1:0] phase;
        logic                        escaped;
        logic                        broadcast;
        logic [epd_pkg::BYTE_W-1:0]  checksum;
        logic [epd_pkg::BYTE_W-1:0]  length_byte;
        epd_pkg::epd_result_t        expected_q[$];
        int                          mismatches;
        int                          checked;
        int                          good_frames;
        int                          bad_frames;

        function new();
            own_address = epd_pkg::OWN_ADDR_RESET;
            length_mask = epd_pkg::MASK_RESET;
            phase       = epd_pkg::PHASE_IDLE;
            escaped     = 1'b0;
            broadcast   = 1'b0;
            checksum    = '0;
            length_byte = epd_pkg::BYTE_W'(epd_pkg::LENGTH_RESET);
            mismatches  = 0;
            checked     = 0;
            good_frames = 0;
            bad_frames  = 0;
        endfunction

        function void write_reg(logic [epd_pkg::CFG_INDEX_W-1:0] idx,
                                logic [epd_pkg::BYTE_W-1:0] data);
            if (idx == epd_pkg::REG_OWN_ADDRESS)
                own_address = data;
            else if (idx == epd_pkg::REG_LENGTH_MASK)
                length_mask = data[epd_pkg::MASK_W-1:0];
        endfunction

        function void note_rx_byte(logic [epd_pkg::BYTE_W-1:0] rx_in);
            epd_pkg::epd_result_t        r;
            logic [epd_pkg::BYTE_W-1:0]  b;
            logic [epd_pkg::INDEX_W-1:0] limit;
            r = '0;
            b = rx_in;
            if (b == epd_pkg::START_BYTE) begin
                phase = epd_pkg::PHASE_DEST;
            end else if (b == epd_pkg::ESCAPE_BYTE) begin
                escaped = 1'b1;
            end else begin
                if (escaped) begin
                    b = b + epd_pkg::ESCAPE_ADD;
                    escaped = 1'b0;
                end
                if (phase == epd_pkg::PHASE_DEST) begin
                    if (b == own_address || b == epd_pkg::BROADCAST_ADDR) begin
                        phase     = epd_pkg::PHASE_SENDER;
                        checksum  = epd_pkg::CHECKSUM_SEED ^ b;
                        broadcast = (b == epd_pkg::BROADCAST_ADDR);
                    end else begin
                        phase = epd_pkg::PHASE_IDLE;
                    end
                end else if (phase == epd_pkg::PHASE_SENDER) begin
                    length_byte    = epd_pkg::BYTE_W'(epd_pkg::LENGTH_RESET);
                    checksum       = checksum ^ b;
                    r.stored_valid = 1'b1;
                    r.stored_index = epd_pkg::PHASE_SENDER;
                    r.stored_value = b;
                    phase          = epd_pkg::PHASE_LENGTH;
                end else if (phase <= epd_pkg::PHASE_LAST) begin
                    limit = {1'b0, length_byte[epd_pkg::MASK_W-1:0] & length_mask}
                            + epd_pkg::CHECKSUM_GAP;
                    if (phase >= limit) begin
                        if (checksum == b)
                            r.packet_good = 1'b1;
                        else
                            r.packet_bad = 1'b1;
                        phase = epd_pkg::PHASE_IDLE;
                    end else begin
                        if (phase == epd_pkg::PHASE_LENGTH)
                            length_byte = b;
                        checksum       = checksum ^ b;
                        r.stored_valid = 1'b1;
                        r.stored_index = phase;
                        r.stored_value = b;
                        phase          = phase + 6'd1;
                    end
                end
            end
            r.is_broadcast   = broadcast;
            r.frame_checksum = checksum;
            if (r.packet_good)
                good_frames++;
            if (r.packet_bad)
                bad_frames++;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [epd_pkg::M_TDATA_W-1:0] tdata);
            epd_pkg::epd_result_t want;
            epd_pkg::epd_result_t got;
            if (expected_q.size() == 0) begin
                $error("result beat with no byte outstanding: tdata 0x%h", tdata);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            got  = tdata[RESULT_W-1:0];
            checked++;
            compare_field("stored_valid", 32'(want.stored_valid), 32'(got.stored_valid));
            compare_field("stored_index", 32'(want.stored_index), 32'(got.stored_index));
            compare_field("stored_value", 32'(want.stored_value), 32'(got.stored_value));
            compare_field("packet_good", 32'(want.packet_good), 32'(got.packet_good));
            compare_field("packet_bad", 32'(want.packet_bad), 32'(got.packet_bad));
            compare_field("is_broadcast", 32'(want.is_broadcast), 32'(got.is_broadcast));
            compare_field("frame_checksum", 32'(want.frame_checksum),
                          32'(got.frame_checksum));
            compare_field("tdata padding", '0, 32'(tdata[epd_pkg::M_TDATA_W-1:RESULT_W]));
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [epd_pkg::S_TDATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [epd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [epd_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [epd_pkg::BYTE_W-1:0]      cfg_data;

    deframe_scoreboard          sb = new();
    int unsigned                cycle_count = 0;
    int                         bytes_sent = 0;
    int                         frames_sent = 0;
    int                         reg_writes = 0;
    bit                         sender_gaps = 1'b1;
    bit                         sink_stalls = 1'b1;
    logic [epd_pkg::BYTE_W-1:0] cur_own = epd_pkg::OWN_ADDR_RESET;
    logic [epd_pkg::MASK_W-1:0] cur_mask = epd_pkg::MASK_RESET;

    escaped_packet_deframer_xor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[escaped_packet_deframer_xor] ERROR");
        $finish;
    end

    initial begin
        int stall;
        int beats;
        beats = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (beats % 40 == 0)
                sink_stalls = ($urandom_range(0, 2) != 0);
            stall = sink_stalls ? $urandom_range(0, 17) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            beats++;
        end
    end

    task automatic send_byte(input logic [epd_pkg::BYTE_W-1:0] b);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    // Values that collide with the start or escape code must be stuffed; others are
    // stuffed now and then as well, unless the stuffed form would collide itself.
    task automatic send_value(input logic [epd_pkg::BYTE_W-1:0] v);
        logic [epd_pkg::BYTE_W-1:0] low;
        low = v - epd_pkg::ESCAPE_ADD;
        if (v == epd_pkg::START_BYTE || v == epd_pkg::ESCAPE_BYTE ||
            (low != epd_pkg::START_BYTE && low != epd_pkg::ESCAPE_BYTE &&
             $urandom_range(0, 7) == 0)) begin
            send_byte(epd_pkg::ESCAPE_BYTE);
            send_byte(low);
        end else begin
            send_byte(v);
        end
    endtask

    // A cut of zero or more stops the frame after that many values past the destination.
    task automatic send_frame(input logic [epd_pkg::BYTE_W-1:0] dest,
                              input logic [epd_pkg::BYTE_W-1:0] sender,
                              input logic [epd_pkg::BYTE_W-1:0] length, input int cut,
                              input bit corrupt);
        logic [epd_pkg::BYTE_W-1:0] content[$];
        logic [epd_pkg::BYTE_W-1:0] sum;
        logic [epd_pkg::BYTE_W-1:0] pay;
        int                         count;
        sum = epd_pkg::CHECKSUM_SEED ^ dest ^ sender ^ length;
        content.push_back(sender);
        content.push_back(length);
        for (int i = 0; i < int'(length[epd_pkg::MASK_W-1:0] & cur_mask); i++) begin
            pay = epd_pkg::BYTE_W'($urandom);
            sum = sum ^ pay;
            content.push_back(pay);
        end
        content.push_back(corrupt ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum);
        count = (cut >= 0 && cut < content.size()) ? cut : content.size();
        send_byte(epd_pkg::START_BYTE);
        send_value(dest);
        for (int i = 0; i < count; i++)
            send_value(content[i]);
        frames_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [epd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [epd_pkg::BYTE_W-1:0] data, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        if (idx == epd_pkg::REG_OWN_ADDRESS)
            cur_own = data;
        else if (idx == epd_pkg::REG_LENGTH_MASK)
            cur_mask = data[epd_pkg::MASK_W-1:0];
        reg_writes++;
    endtask

    task automatic set_config(input logic [epd_pkg::BYTE_W-1:0] own,
                              input logic [epd_pkg::BYTE_W-1:0] mask);
        wait_results_done();
        write_reg(epd_pkg::REG_OWN_ADDRESS, own, 1'b0);
        write_reg(epd_pkg::REG_LENGTH_MASK, mask, 1'b1);
    endtask

    function automatic logic [epd_pkg::BYTE_W-1:0] pick_dest();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return cur_own;
        else if (r < 80)
            return epd_pkg::BROADCAST_ADDR;
        return epd_pkg::BYTE_W'($urandom);
    endfunction

    function automatic logic [epd_pkg::BYTE_W-1:0] pick_length();
        logic [epd_pkg::BYTE_W-1:0] len;
        len = epd_pkg::BYTE_W'($urandom);
        if ($urandom_range(0, 3) != 0)
            len[4:3] = 2'b00;
        return len;
    endfunction

    task automatic run_random(input int n_bytes);
        int target;
        int kind;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(pick_dest(), epd_pkg::BYTE_W'($urandom), pick_length(), -1,
                           $urandom_range(0, 4) == 0);
            end else if (kind < 85) begin
                send_frame(pick_dest(), epd_pkg::BYTE_W'($urandom), pick_length(),
                           $urandom_range(0, 6), 1'b0);
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 4) == 0)
                        send_byte($urandom_range(0, 1) ? epd_pkg::START_BYTE
                                                       : epd_pkg::ESCAPE_BYTE);
                    else
                        send_byte(epd_pkg::BYTE_W'($urandom));
                end
            end
            if ($urandom_range(0, 29) == 0)
                wait_results_done();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_frame(epd_pkg::OWN_ADDR_RESET, 8'h00, 8'h01, -1, 1'b0);
        send_byte(8'h55);
        send_byte(epd_pkg::ESCAPE_BYTE);
        send_byte(8'h05);
        send_frame(epd_pkg::BROADCAST_ADDR, 8'hFF, 8'hE0, -1, 1'b1);
        send_byte(epd_pkg::START_BYTE);
        send_byte(8'h33);
        send_byte(8'h44);
        // A pending escape survives the start byte, then a double escape wraps to 0x08.
        send_byte(epd_pkg::ESCAPE_BYTE);
        send_byte(epd_pkg::START_BYTE);
        send_byte(8'hEF);
        send_byte(epd_pkg::ESCAPE_BYTE);
        send_byte(epd_pkg::ESCAPE_BYTE);
        send_byte(8'hF8);
        send_byte(8'h00);
        send_byte(8'h00);

        send_frame(epd_pkg::BROADCAST_ADDR, 8'h5A, 8'hFF, -1, 1'b0);
        send_frame(epd_pkg::OWN_ADDR_RESET, epd_pkg::BYTE_W'($urandom), 8'h14, 5, 1'b0);
        wait_results_done();
        write_reg(epd_pkg::REG_LENGTH_MASK, 8'd1, 1'b1);
        send_byte(8'h3C);
        wait_results_done();
        write_reg(8'd2, 8'hFF, 1'b0);
        write_reg(8'hFF, 8'h00, 1'b1);

        set_config(8'h00, 8'd0);
        run_random(120);
        set_config(8'hFF, 8'd31);
        run_random(120);
        set_config(epd_pkg::BYTE_W'($urandom), epd_pkg::BYTE_W'($urandom_range(1, 7)));
        run_random(120);
        set_config(8'hA5, 8'd16);
        run_random(120);
        set_config(epd_pkg::OWN_ADDR_RESET, epd_pkg::BYTE_W'(epd_pkg::MASK_RESET));
        run_random(120);

        wait_results_done();
        repeat (10) @(posedge aclk);
        $display("Sent %0d line bytes in %0d frames plus noise, %0d result beats checked,",
                 bytes_sent, frames_sent, sb.checked);
        $display("%0d register writes, %0d good and %0d bad checksums.",
                 reg_writes, sb.good_frames, sb.bad_frames);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[escaped_packet_deframer_xor] OK");
        end else begin
            $display("[escaped_packet_deframer_xor] ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+sv
sv/epd_pkg.sv
sv/epd_core.sv
sv/escaped_packet_deframer_xor.sv
sv/epd_checker.sv
test/tb_escaped_packet_deframer_xor.sv
